>>> rtl/core/bmpd_pkg.sv
`timescale 1ns / 1ps
package bmpd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_MASKS   = 3'd2,
    PH_PALETTE = 3'd3,
    PH_SKIP    = 3'd4,
    PH_PIXELS  = 3'd5,
    PH_PAD     = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    MODE_UNKNOWN = 3'd0,
    MODE_INDEX   = 3'd1,
    MODE_5551    = 3'd2,
    MODE_565     = 3'd3,
    MODE_888     = 3'd4,
    MODE_8888    = 3'd5
  } mode_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SIG  = 2'd1;
  localparam logic [1:0] ST_BAD_FMT  = 2'd2;
  localparam logic [1:0] ST_BAD_SIZE = 2'd3;

  localparam logic [15:0] BMP_SIG = 16'h4D42;

  function automatic logic [31:0] mask_5551(input logic [1:0] k);
    unique case (k)
      2'd0: mask_5551 = 32'h00007C00;
      2'd1: mask_5551 = 32'h000003E0;
      2'd2: mask_5551 = 32'h0000001F;
      default: mask_5551 = 32'h00008000;
    endcase
  endfunction

  function automatic logic [31:0] mask_565(input logic [1:0] k);
    unique case (k)
      2'd0: mask_565 = 32'h0000F800;
      2'd1: mask_565 = 32'h000007E0;
      2'd2: mask_565 = 32'h0000001F;
      default: mask_565 = 32'h00000000;
    endcase
  endfunction

  function automatic logic [2:0] mode_bytes(input mode_t m);
    unique case (m)
      MODE_5551, MODE_565: mode_bytes = 3'd2;
      MODE_888: mode_bytes = 3'd3;
      MODE_8888: mode_bytes = 3'd4;
      default: mode_bytes = 3'd1;
    endcase
  endfunction

endpackage

>>> rtl/core/bmp_stream_pixel_decoder.sv
`timescale 1ns / 1ps
// Streaming BMP decoder: one file byte per transaction, one byte per cycle sustained while out_ready stays high.
// Each result passes through the palette read stage, then the output
// register. The palette RAM read port sets the pipeline depth.
// Reset (rst, synchronous) returns the parser to idle; a byte with first_byte
// set starts a file. Palette RAM is not cleared; only loaded entries are used.
module bmp_stream_pixel_decoder #(
  parameter int MAX_DIM = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [11:0] x_pos,
  output logic [11:0] y_pos,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        blend,
  output logic [1:0]  status,
  output logic        last
);
  import bmpd_pkg::*;

  localparam int PA = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int PL = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [12:0] DIM_MAX = 13'(MAX_DIM);

  // ---------------- parse state
  phase_t      phase;
  logic [31:0] file_position, header_shift, data_offset, colors_used;
  logic [12:0] image_width, image_height;
  logic [15:0] bits_per_pixel;
  logic [1:0]  mask_match;
  mode_t       pixel_mode;
  logic [PL-1:0] palette_loaded;
  logic [23:0] pixel_bytes;
  logic [1:0]  byte_in_pixel, pad_left;
  logic [11:0] column, row;

  // ---------------- stage 1 (after palette read issue)
  logic        s1_valid, s1_kind, s1_index, s1_hit, s1_blend, s1_last;
  logic [11:0] s1_x, s1_y;
  logic [7:0]  s1_r, s1_g, s1_b, s1_a;
  logic [1:0]  s1_status;
  logic [31:0] pal_rd;

  logic advance, s1_ready, out_load;
  assign out_load = !out_valid || out_ready;
  assign s1_ready = !s1_valid || out_load;
  assign in_ready = s1_ready;
  assign advance = in_valid && in_ready;

  // ---------------- combinational step
  phase_t      ph_eff, phase_n;
  logic [31:0] fp_n, hs_n, do_n, cu_n, fp_cur, hs_shift;
  logic [12:0] iw_n, ih_n, dim_clamp;
  logic [15:0] bpp_n;
  logic [1:0]  mm_n, bip_n, pad_n, k;
  mode_t       mode_n;
  logic [PL-1:0] pl_n, target;
  logic [23:0] pb_n;
  logic [11:0] col_n, row_n;
  logic        r_valid, r_kind, r_index, r_hit, r_blend, r_last;
  logic [11:0] r_x, r_y;
  logic [7:0]  r_r, r_g, r_b, r_a;
  logic [1:0]  r_status;
  logic        pw_en;
  logic [31:0] pw_data;
  logic [15:0] w;
  logic [2:0]  nb;
  logic        row_end, active;
  logic [14:0] row_bytes;
  logic [31:0] ncu;
  logic [1:0]  mm_t;

  always_comb begin
    phase_n = phase; fp_n = file_position; hs_n = header_shift; do_n = data_offset;
    cu_n = colors_used; iw_n = image_width; ih_n = image_height; bpp_n = bits_per_pixel;
    mm_n = mask_match; mode_n = pixel_mode; pl_n = palette_loaded; pb_n = pixel_bytes;
    bip_n = byte_in_pixel; pad_n = pad_left; col_n = column; row_n = row;
    if (first_byte) begin
      phase_n = PH_HEADER; fp_n = '0; hs_n = '0; do_n = '0; cu_n = '0; iw_n = '0;
      ih_n = '0; bpp_n = '0; mm_n = '0; mode_n = MODE_UNKNOWN; pl_n = '0; pb_n = '0;
      bip_n = '0; pad_n = '0; col_n = '0; row_n = '0;
    end
    r_valid = 1'b0; r_kind = 1'b0; r_index = 1'b0; r_hit = 1'b0; r_blend = 1'b0;
    r_last = 1'b0; r_x = '0; r_y = '0; r_r = '0; r_g = '0; r_b = '0; r_a = '0;
    r_status = ST_OK; pw_en = 1'b0; pw_data = '0;
    fp_cur = fp_n;
    hs_shift = {data_byte, hs_n[31:8]};
    dim_clamp = (hs_shift > 32'(MAX_DIM)) ? DIM_MAX + 13'd1 : hs_shift[12:0];
    k = 2'(((fp_cur - 32'd54) >> 2));
    w = {data_byte, pb_n[7:0]};
    nb = mode_bytes(mode_n);
    // palette target uses values current after header
    ncu = cu_n;
    if (ncu == 0 && bpp_n == 16'd8) ncu = 32'd256;
    target = (ncu > 32'(PALETTE_ENTRIES)) ? PL'(PALETTE_ENTRIES) : PL'(ncu);
    row_end = ({1'b0, col_n} + 13'd1) >= iw_n;
    row_bytes = 15'(iw_n) * 15'(nb);
    mm_t = mm_n;
    active = phase_n != PH_IDLE && phase_n != PH_DONE;
    ph_eff = phase_n;
    if (active) begin
      if (fp_cur != 32'hFFFF_FFFF) fp_n = fp_cur + 32'd1;
      if (phase_n == PH_SKIP && fp_cur >= do_n) ph_eff = PH_PIXELS;
      unique case (ph_eff)
        PH_HEADER: begin
          hs_n = hs_shift;
          unique case (fp_cur)
            32'd1: if (hs_shift[31:16] != BMP_SIG) begin
              phase_n = PH_DONE; r_valid = 1'b1; r_kind = 1'b1; r_last = 1'b1;
              r_status = ST_BAD_SIG;
            end
            32'd13: do_n = hs_shift;
            32'd21: iw_n = dim_clamp;
            32'd25: ih_n = dim_clamp;
            32'd29: bpp_n = hs_shift[31:16];
            32'd49: cu_n = hs_shift;
            32'd53: begin
              if (bpp_n != 16'd8 && bpp_n != 16'd16 && bpp_n != 16'd24 &&
                  bpp_n != 16'd32) begin
                phase_n = PH_DONE; r_valid = 1'b1; r_kind = 1'b1; r_last = 1'b1;
                r_status = ST_BAD_FMT;
              end else if (iw_n == 0 || iw_n > DIM_MAX || ih_n == 0 ||
                           ih_n > DIM_MAX) begin
                phase_n = PH_DONE; r_valid = 1'b1; r_kind = 1'b1; r_last = 1'b1;
                r_status = ST_BAD_SIZE;
              end else begin
                mode_n = (bpp_n == 16'd8) ? MODE_INDEX : (bpp_n == 16'd24) ? MODE_888 :
                         (bpp_n == 16'd32) ? MODE_8888 : MODE_UNKNOWN;
                if (bpp_n == 16'd16) begin
                  mm_n = 2'b11; phase_n = PH_MASKS;
                end else begin
                  pl_n = '0; bip_n = '0; pb_n = '0; col_n = '0; pad_n = '0;
                  row_n = 12'(ih_n - 13'd1);
                  phase_n = (target != 0) ? PH_PALETTE : PH_SKIP;
                end
              end
            end
            default: ;
          endcase
        end
        PH_MASKS: begin
          hs_n = hs_shift;
          if (fp_cur[1:0] == 2'd1) begin  // (pos-54)&3 == 3
            if (hs_shift != mask_5551(k)) mm_t[0] = 1'b0;
            if (hs_shift != mask_565(k)) mm_t[1] = 1'b0;
            mm_n = mm_t;
            if (k == 2'd3) begin
              if (mm_t[0] || mm_t[1]) begin
                mode_n = mm_t[0] ? MODE_5551 : MODE_565;
                pl_n = '0; bip_n = '0; pb_n = '0; col_n = '0; pad_n = '0;
                row_n = 12'(ih_n - 13'd1);
                phase_n = (target != 0) ? PH_PALETTE : PH_SKIP;
              end else begin
                phase_n = PH_DONE; r_valid = 1'b1; r_kind = 1'b1; r_last = 1'b1;
                r_status = ST_BAD_FMT;
              end
            end
          end
        end
        PH_PALETTE: begin
          if (byte_in_pixel != 2'd3 || first_byte) begin
            pb_n[8*bip_n +: 8] = data_byte;
            bip_n = bip_n + 2'd1;
          end else begin
            pw_en = 1'b1; pw_data = {data_byte, pb_n};
            pl_n = pl_n + PL'(1); bip_n = '0; pb_n = '0;
            if (pl_n >= target) phase_n = PH_SKIP;
          end
        end
        PH_PIXELS: begin
          phase_n = PH_PIXELS;
          if ({1'b0, bip_n} + 3'd1 < nb) begin
            pb_n[8*bip_n +: 8] = data_byte;
            bip_n = bip_n + 2'd1;
          end else begin
            r_valid = 1'b1; r_a = 8'd255;
            unique case (mode_n)
              MODE_INDEX: begin
                r_index = 1'b1;
                r_hit = {1'b0, data_byte} < 9'(pl_n);
              end
              MODE_5551: begin
                r_r = {w[14:10], 3'b0}; r_g = {w[9:5], 3'b0}; r_b = {w[4:0], 3'b0};
                r_a = w[15] ? 8'd255 : 8'd0; r_blend = 1'b1;
              end
              MODE_565: begin
                r_r = {w[15:11], 3'b0}; r_g = {w[10:5], 2'b0}; r_b = {w[4:0], 3'b0};
              end
              MODE_888: begin
                r_r = data_byte; r_g = pb_n[15:8]; r_b = pb_n[7:0];
              end
              default: begin
                r_r = pb_n[23:16]; r_g = pb_n[15:8]; r_b = pb_n[7:0];
                r_a = data_byte; r_blend = 1'b1;
              end
            endcase
            bip_n = '0; pb_n = '0;
            r_x = col_n; r_y = row_n;
            r_last = (row_n == 0) && row_end;
            if (r_last) phase_n = PH_DONE;
            else if (row_end) begin
              col_n = '0; row_n = row_n - 12'd1;
              pad_n = 2'(3'd4 - {1'b0, row_bytes[1:0]});
              if (pad_n != 0) phase_n = PH_PAD;
            end else col_n = col_n + 12'd1;
          end
        end
        PH_PAD: begin
          pad_n = pad_n - 2'd1;
          if (pad_n == 0) phase_n = PH_PIXELS;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; file_position <= '0; header_shift <= '0; data_offset <= '0;
      colors_used <= '0; image_width <= '0; image_height <= '0; bits_per_pixel <= '0;
      mask_match <= '0; pixel_mode <= MODE_UNKNOWN; palette_loaded <= '0;
      pixel_bytes <= '0; byte_in_pixel <= '0; pad_left <= '0; column <= '0; row <= '0;
      s1_valid <= 1'b0;
    end else if (advance) begin
      phase <= phase_n; file_position <= fp_n; header_shift <= hs_n; data_offset <= do_n;
      colors_used <= cu_n; image_width <= iw_n; image_height <= ih_n;
      bits_per_pixel <= bpp_n; mask_match <= mm_n; pixel_mode <= mode_n;
      palette_loaded <= pl_n; pixel_bytes <= pb_n; byte_in_pixel <= bip_n;
      pad_left <= pad_n; column <= col_n; row <= row_n;
      s1_valid <= r_valid;
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind <= r_kind; s1_index <= r_index; s1_hit <= r_hit; s1_blend <= r_blend;
      s1_last <= r_last; s1_x <= r_x; s1_y <= r_y; s1_r <= r_r; s1_g <= r_g;
      s1_b <= r_b; s1_a <= r_a; s1_status <= r_status;
    end
  end

  // palette write happens before any read of the same entry (read issued later)
  bmpd_ram #(.WIDTH(32), .DEPTH(1 << PA)) u_palette (
    .clk     (clk),
    .wr_en   (advance && pw_en),
    .wr_addr (palette_loaded[PA-1:0]),
    .wr_data (pw_data),
    .rd_en   (advance),
    .rd_addr (data_byte[PA-1:0]),
    .rd_data (pal_rd)
  );

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      kind <= s1_kind; x_pos <= s1_x; y_pos <= s1_y; alpha <= s1_a;
      blend <= s1_blend; status <= s1_status; last <= s1_last;
      if (s1_index) begin
        red   <= s1_hit ? pal_rd[23:16] : 8'd0;
        green <= s1_hit ? pal_rd[15:8] : 8'd0;
        blue  <= s1_hit ? pal_rd[7:0] : 8'd0;
      end else begin
        red <= s1_r; green <= s1_g; blue <= s1_b;
      end
    end
  end
endmodule

>>> rtl/core/bmpd_ram.sv
`timescale 1ns / 1ps
module bmpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

>>> sim/tb_bmp_stream_pixel_decoder.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic        kind;
  logic [11:0] x_pos;
  logic [11:0] y_pos;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        blend;
  logic [1:0]  status;
  logic        last;
} bmp_out_t;

class bmp_pixel_scoreboard;
  bmpd_pkg::phase_t ph;
  bmpd_pkg::mode_t  mode;
  logic [31:0] fpos, shift, doff, colors;
  logic [15:0] bpp;
  logic [12:0] wid, hgt;
  logic [1:0]  mm;
  logic [31:0] pal [256];
  int unsigned loaded, bip, pad;
  logic [23:0] pb;
  logic [11:0] col, row;
  bmp_out_t    pending_px[$];
  int          errors, n_pix, n_stat;

  function new();
    ph = bmpd_pkg::PH_IDLE;
    errors = 0;
    n_pix = 0;
    n_stat = 0;
    restart();
    ph = bmpd_pkg::PH_IDLE;
  endfunction

  function void restart();
    ph = bmpd_pkg::PH_HEADER;
    mode = bmpd_pkg::MODE_UNKNOWN;
    fpos = 0; shift = 0; doff = 0; colors = 0; bpp = 0;
    wid = 0; hgt = 0; mm = 0; loaded = 0; bip = 0; pad = 0;
    pb = 0; col = 0; row = 0;
  endfunction

  function void put_status(logic [1:0] code);
    bmp_out_t e;
    e = '0;
    e.kind = 1'b1;
    e.status = code;
    e.last = 1'b1;
    ph = bmpd_pkg::PH_DONE;
    pending_px.push_back(e);
  endfunction

  function logic [12:0] clamp(logic [31:0] v);
    return (v > 32'd4096) ? 13'd4097 : v[12:0];
  endfunction

  function int unsigned pal_target();
    logic [31:0] n;
    n = colors;
    if (n == 0 && bpp == 16'd8) n = 256;
    if (n > 256) n = 256;
    return n;
  endfunction

  function void open_palette();
    loaded = 0; bip = 0; pb = 0; col = 0; pad = 0;
    row = 12'(hgt - 13'd1);
    ph = (pal_target() != 0) ? bmpd_pkg::PH_PALETTE : bmpd_pkg::PH_SKIP;
  endfunction

  function int unsigned px_bytes();
    case (mode)
      bmpd_pkg::MODE_5551, bmpd_pkg::MODE_565: return 2;
      bmpd_pkg::MODE_888: return 3;
      bmpd_pkg::MODE_8888: return 4;
      default: return 1;
    endcase
  endfunction

  function void do_header(logic [31:0] pos, logic [7:0] b);
    shift = {b, shift[31:8]};
    case (pos)
      1: if (shift[31:16] != bmpd_pkg::BMP_SIG) put_status(bmpd_pkg::ST_BAD_SIG);
      13: doff = shift;
      21: wid = clamp(shift);
      25: hgt = clamp(shift);
      29: bpp = shift[31:16];
      49: colors = shift;
      53: begin
        case (bpp)
          16'd8: mode = bmpd_pkg::MODE_INDEX;
          16'd16: mode = bmpd_pkg::MODE_UNKNOWN;
          16'd24: mode = bmpd_pkg::MODE_888;
          16'd32: mode = bmpd_pkg::MODE_8888;
          default: begin
            put_status(bmpd_pkg::ST_BAD_FMT);
            return;
          end
        endcase
        if (wid == 0 || wid > 4096 || hgt == 0 || hgt > 4096) begin
          put_status(bmpd_pkg::ST_BAD_SIZE);
        end else if (bpp == 16'd16) begin
          mm = 2'b11;
          ph = bmpd_pkg::PH_MASKS;
        end else begin
          open_palette();
        end
      end
      default: ;
    endcase
  endfunction

  function void do_mask(logic [31:0] pos, logic [7:0] b);
    logic [31:0] rel, m5551, m565;
    logic [1:0]  k;
    rel = pos - 32'd54;
    k = rel[3:2];
    shift = {b, shift[31:8]};
    if (rel[1:0] != 2'd3) return;
    case (k)
      2'd0: begin m5551 = 32'h7C00; m565 = 32'hF800; end
      2'd1: begin m5551 = 32'h03E0; m565 = 32'h07E0; end
      2'd2: begin m5551 = 32'h001F; m565 = 32'h001F; end
      default: begin m5551 = 32'h8000; m565 = 32'h0000; end
    endcase
    if (shift != m5551) mm[0] = 1'b0;
    if (shift != m565) mm[1] = 1'b0;
    if (k == 2'd3) begin
      if (mm[0]) mode = bmpd_pkg::MODE_5551;
      else if (mm[1]) mode = bmpd_pkg::MODE_565;
      else begin
        put_status(bmpd_pkg::ST_BAD_FMT);
        return;
      end
      open_palette();
    end
  endfunction

  function void do_palette(logic [7:0] b);
    if (bip < 3) begin
      pb[8*bip +: 8] = b;
      bip++;
      return;
    end
    if (loaded < 256) pal[loaded] = {b, pb};
    loaded++;
    bip = 0;
    pb = 0;
    if (loaded >= pal_target()) ph = bmpd_pkg::PH_SKIP;
  endfunction

  function void do_pixel(logic [7:0] b);
    int unsigned nb;
    logic [15:0] w;
    bmp_out_t e;
    logic [31:0] ent;
    nb = px_bytes();
    w = {b, pb[7:0]};
    if (bip + 1 < nb) begin
      pb[8*bip +: 8] = b;
      bip++;
      return;
    end
    e = '0;
    e.alpha = 8'hFF;
    case (mode)
      bmpd_pkg::MODE_INDEX: if (b < loaded) begin
        ent = pal[b];
        e.blue = ent[7:0]; e.green = ent[15:8]; e.red = ent[23:16];
      end
      bmpd_pkg::MODE_5551: begin
        e.red = {w[14:10], 3'b0}; e.green = {w[9:5], 3'b0}; e.blue = {w[4:0], 3'b0};
        e.alpha = w[15] ? 8'hFF : 8'h00;
        e.blend = 1'b1;
      end
      bmpd_pkg::MODE_565: begin
        e.red = {w[15:11], 3'b0}; e.green = {w[10:5], 2'b0}; e.blue = {w[4:0], 3'b0};
      end
      bmpd_pkg::MODE_888: begin
        e.red = b; e.green = pb[15:8]; e.blue = pb[7:0];
      end
      default: begin
        e.red = pb[23:16]; e.green = pb[15:8]; e.blue = pb[7:0];
        e.alpha = b; e.blend = 1'b1;
      end
    endcase
    bip = 0;
    pb = 0;
    e.x_pos = col;
    e.y_pos = row;
    e.last = (row == 0 && 13'(col) + 13'd1 >= wid);
    pending_px.push_back(e);
    if (e.last) begin
      ph = bmpd_pkg::PH_DONE;
    end else if (13'(col) + 13'd1 >= wid) begin
      col = 0;
      row = row - 12'd1;
      pad = (4 - ((wid * nb) & 3)) & 3;
      if (pad != 0) ph = bmpd_pkg::PH_PAD;
    end else begin
      col = col + 12'd1;
    end
  endfunction

  // Called once per accepted input transaction.
  function void note_byte(logic [7:0] b, logic first);
    logic [31:0] pos;
    if (first) restart();
    if (ph == bmpd_pkg::PH_IDLE || ph == bmpd_pkg::PH_DONE) return;
    pos = fpos;
    if (fpos != 32'hFFFF_FFFF) fpos++;
    if (ph == bmpd_pkg::PH_SKIP && pos >= doff) ph = bmpd_pkg::PH_PIXELS;
    case (ph)
      bmpd_pkg::PH_HEADER: do_header(pos, b);
      bmpd_pkg::PH_MASKS: do_mask(pos, b);
      bmpd_pkg::PH_PALETTE: do_palette(b);
      bmpd_pkg::PH_PIXELS: do_pixel(b);
      bmpd_pkg::PH_PAD: begin
        pad = (pad - 1) & 3;
        if (pad == 0) ph = bmpd_pkg::PH_PIXELS;
      end
      default: ;
    endcase
  endfunction

  function void check_result(bmp_out_t got);
    bmp_out_t e;
    if (pending_px.size() == 0) begin
      $error("result with nothing expected: %p", got);
      errors++;
      return;
    end
    e = pending_px.pop_front();
    if (e.kind) n_stat++;
    else n_pix++;
    if (got.kind != e.kind) begin $error("kind exp %0d got %0d", e.kind, got.kind); errors++; end
    if (got.x_pos != e.x_pos) begin $error("x_pos exp %0d got %0d", e.x_pos, got.x_pos); errors++; end
    if (got.y_pos != e.y_pos) begin $error("y_pos exp %0d got %0d", e.y_pos, got.y_pos); errors++; end
    if (got.red != e.red) begin $error("red exp %0h got %0h", e.red, got.red); errors++; end
    if (got.green != e.green) begin $error("green exp %0h got %0h", e.green, got.green); errors++; end
    if (got.blue != e.blue) begin $error("blue exp %0h got %0h", e.blue, got.blue); errors++; end
    if (got.alpha != e.alpha) begin $error("alpha exp %0h got %0h", e.alpha, got.alpha); errors++; end
    if (got.blend != e.blend) begin $error("blend exp %0d got %0d", e.blend, got.blend); errors++; end
    if (got.status != e.status) begin $error("status exp %0d got %0d", e.status, got.status); errors++; end
    if (got.last != e.last) begin $error("last exp %0d got %0d", e.last, got.last); errors++; end
  endfunction
endclass

module tb_bmp_stream_pixel_decoder;
  import bmpd_pkg::*;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        kind, blend, last;
  logic [11:0] x_pos, y_pos;
  logic [7:0]  red, green, blue, alpha;
  logic [1:0]  status;

  bmp_pixel_scoreboard sb;
  logic [7:0] file_q[$];
  int  calm, hold, n_files, n_bytes;

  bmp_stream_pixel_decoder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .first_byte(first_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .x_pos(x_pos), .y_pos(y_pos),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .blend(blend), .status(status), .last(last)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL bmp_stream_pixel_decoder");
    $finish;
  end

  // result side: random stall drawn per accepted result
  always @(posedge clk) begin
    if (rst) begin
      hold = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result({kind, x_pos, y_pos, red, green, blue, alpha, blend, status, last});
        hold = calm ? 0 : $urandom_range(0, 12);
      end else if (hold > 0) begin
        hold--;
      end
      out_ready <= (hold == 0);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic f);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    first_byte <= f;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, f);
    n_bytes++;
  endtask

  task automatic push32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  // early_off: data offset points at or before the end of the palette; extra: skip bytes before pixels;
  // keep: cap on pixel-area bytes (-1 = whole image)
  task automatic make_file(input logic [15:0] sig, input logic [15:0] bpp,
                           input logic [31:0] w, input logic [31:0] h,
                           input logic [31:0] colors, input int mask_sel,
                           input bit early_off, input int extra, input int keep,
                           input int trail);
    int npal, natural, nb, row_b, total;
    logic [31:0] m5551 [4], m565 [4];
    m5551 = '{32'h7C00, 32'h03E0, 32'h001F, 32'h8000};
    m565 = '{32'hF800, 32'h07E0, 32'h001F, 32'h0000};
    file_q.delete();
    npal = (colors == 0 && bpp == 16'd8) ? 256 : (colors > 256 ? 256 : colors);
    natural = 54 + (bpp == 16'd16 ? 16 : 0) + 4 * npal;
    file_q.push_back(sig[7:0]);
    file_q.push_back(sig[15:8]);
    push32($urandom);
    push32($urandom);
    push32(early_off ? $urandom_range(0, natural) : natural + extra);
    push32(40);
    push32(w);
    push32(h);
    push32({bpp, 16'd1});
    for (int i = 0; i < 4; i++) push32($urandom);
    push32(colors);
    push32($urandom);
    if (bpp == 16'd16) begin
      for (int k = 0; k < 4; k++) begin
        if (mask_sel == 0) push32(m5551[k]);
        else if (mask_sel == 1) push32(m565[k]);
        else push32(k == mask_sel - 2 ? $urandom : m5551[k]);
      end
    end
    for (int i = 0; i < 4 * npal; i++) file_q.push_back($urandom);
    if (!early_off) for (int i = 0; i < extra; i++) file_q.push_back($urandom);
    nb = bpp / 8;
    if (w >= 1 && w <= 4096 && h >= 1 && h <= 4096 && nb inside {1, 2, 3, 4}) begin
      row_b = ((w * nb + 3) / 4) * 4;
      total = row_b * h;
      if (keep >= 0 && keep < total) total = keep;
      for (int i = 0; i < total; i++) begin
        if (nb == 1 && $urandom_range(0, 3) != 0)
          file_q.push_back($urandom_range(0, npal + 1 > 255 ? 255 : npal + 1));
        else
          file_q.push_back($urandom);
      end
    end
    for (int i = 0; i < trail; i++) file_q.push_back($urandom);
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == 0);
    n_files++;
  endtask

  task automatic random_file();
    int pick, sel;
    logic [15:0] bpp;
    calm = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 4);
    bpp = (sel == 0) ? 16'd8 : (sel <= 2) ? 16'd16 : (sel == 3) ? 16'd24 : 16'd32;
    if (pick < 78) begin
      make_file(BMP_SIG, bpp, $urandom_range(1, 6), $urandom_range(1, 4),
                (bpp == 16'd8) ? $urandom_range(1, 8)
                               : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0),
                (sel == 1) ? 0 : 1, $urandom_range(0, 9) == 0, $urandom_range(0, 3),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : -1,
                $urandom_range(0, 3));
    end else if (pick < 83) begin
      make_file($urandom, bpp, 2, 2, 1, 0, 0, 0, -1, 2);
    end else if (pick < 88) begin
      make_file(BMP_SIG, $urandom, 2, 2, 1, 0, 0, 0, -1, 1);
    end else if (pick < 93) begin
      make_file(BMP_SIG, bpp, $urandom_range(0, 1) ? 0 : $urandom,
                $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd4097, 1, 0, 0, 0, -1, 1);
    end else if (pick < 97) begin
      make_file(BMP_SIG, 16'd16, 2, 1, 0, $urandom_range(2, 5), 0, 0, -1, 2);
    end else begin
      for (int i = 0; i < 4; i++) send_byte($urandom, 1'b0);
    end
  endtask

  initial begin
    sb = new();
    calm = 0;
    n_files = 0;
    n_bytes = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    first_byte = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bytes before any file are ignored
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // indices past the palette give black; trailing bytes ignored
    make_file(BMP_SIG, 16'd8, 3, 2, 4, 0, 0, 0, -1, 3);
    send_byte(8'hA5, 1'b0);
    make_file(BMP_SIG, 16'd16, 3, 2, 0, 0, 0, 0, -1, 0);
    make_file(BMP_SIG, 16'd16, 1, 3, 0, 1, 0, 2, -1, 0);
    make_file(BMP_SIG, 16'd16, 2, 1, 0, 5, 0, 0, -1, 0);
    make_file(BMP_SIG, 16'd24, 1, 2, 0, 0, 0, 0, -1, 0);
    make_file(BMP_SIG, 16'd32, 2, 2, 2, 0, 0, 3, -1, 1);
    make_file(BMP_SIG, 16'd24, 3, 2, 1, 0, 1, 0, -1, 0);
    make_file(16'h4D43, 16'd8, 1, 1, 1, 0, 0, 0, -1, 2);
    make_file(BMP_SIG, 16'd12, 1, 1, 0, 0, 0, 0, -1, 0);
    make_file(BMP_SIG, 16'd1, 0, 1, 0, 0, 0, 0, -1, 0);
    make_file(BMP_SIG, 16'd24, 0, 1, 0, 0, 0, 0, -1, 0);
    make_file(BMP_SIG, 16'd24, 1, 32'hFFFF_FFFF, 0, 0, 0, 0, -1, 0);
    make_file(BMP_SIG, 16'd32, 4097, 1, 0, 0, 0, 0, -1, 0);
    // widest and tallest images, both cut short by the next file
    calm = 1;
    make_file(BMP_SIG, 16'd8, 4096, 1, 2, 0, 0, 0, 16, 0);
    calm = 0;
    make_file(BMP_SIG, 16'd24, 1, 4096, 0, 0, 0, 0, 12, 0);
    make_file(BMP_SIG, 16'd32, 1, 1, 0, 0, 0, 0, -1, 0);

    while (n_bytes < 1200) random_file();

    calm = 0;
    in_valid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending_px.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_px.size());
      sb.errors++;
    end
    $display("Decoded %0d files: %0d pixels and %0d status results checked.",
             n_files, sb.n_pix, sb.n_stat);
    if (sb.errors == 0) begin
      $display("PASS bmp_stream_pixel_decoder");
    end else begin
      $display("FAIL bmp_stream_pixel_decoder");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/bmpd_pkg.sv
rtl/core/bmpd_ram.sv
rtl/core/bmp_stream_pixel_decoder.sv
sim/tb_bmp_stream_pixel_decoder.sv
